@@ rtl/exon_intron_locator_defines.svh @@
// assertion macros for the exon intron locator
`ifndef EXON_INTRON_LOCATOR_DEFINES_SVH
`define EXON_INTRON_LOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define EIL_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define EIL_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define EIL_ASSERT_IMPLIES(label, clk, rst, a, b)
`define EIL_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ rtl/eil_pkg.sv @@
// shared types and constants of the exon intron locator
package eil_pkg;
   localparam int MAX_EXONS_DEF = 64;
   localparam int ID_W = 16;
   localparam int COORD_W = 31;
   localparam int GENE_W = 30;
   localparam int REGION_W = 17;

   typedef enum logic [1:0] {
      ST_STORED  = 2'd0,
      ST_FULL    = 2'd1,
      ST_MATCH   = 2'd2,
      ST_NOMATCH = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // query word travelling down the cell row
   typedef struct packed {
      logic                valid;
      logic [COORD_W-1:0]  pos;
      logic                done;
      logic                is_exon;
      logic [REGION_W-1:0] region;
   } token_type;
endpackage

@@ rtl/eil_if.sv @@
// handshake channels of the exon intron locator
interface eil_req_if;
   logic                             valid;
   logic                             ready;
   logic                             cmd;
   logic [eil_pkg::ID_W-1:0]         exon_id;
   logic [eil_pkg::COORD_W-1:0]      exon_first;
   logic [eil_pkg::COORD_W-1:0]      exon_last;
   logic signed [eil_pkg::COORD_W-1:0] rel_position;
   modport source (output valid, cmd, exon_id, exon_first, exon_last, rel_position,
                   input ready);
   modport sink (input valid, cmd, exon_id, exon_first, exon_last, rel_position,
                 output ready);
endinterface

interface eil_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic                               is_exon;
   logic signed [eil_pkg::REGION_W-1:0] region_number;
   modport source (output valid, status, is_exon, region_number, input ready);
   modport sink (input valid, status, is_exon, region_number, output ready);
endinterface

interface eil_csr_if;
   logic                        valid;
   logic                        ready;
   logic [eil_pkg::GENE_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ rtl/exon_intron_locator.sv @@
// top level of the exon intron locator
// usage:
// - req_bus carries one word per command: cmd add stores an exon at the next
//   free table slot, cmd query classifies a signed relative position
// - rsp_bus returns exactly one word per command: stored, full, match, no match
// - csr_bus writes gene_start; always ready, write only while idle
// responses and acceptance:
// - an add answers in the cycle after acceptance; next word waits for rsp_ready
// - a query walks the row of MAX_EXONS cells, one cell per cycle, and
//   answers from the output register once its word leaves the last cell
// - one command in flight at a time; a query occupies the block until its
//   word leaves the last cell
// reset:
// - clears the fill count, the cell valid bits, the reversed flag, gene_start
//   and the output valid bit; exon contents are left as they were
// stall:
// - a waiting response holds in the output register; req_ready stays low
//   until that word can leave, nothing is lost
module exon_intron_locator #(
   parameter int MAX_EXONS = eil_pkg::MAX_EXONS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   eil_req_if.sink   req_bus,
   eil_rsp_if.source rsp_bus,
   eil_csr_if.sink   csr_bus
);
`include "exon_intron_locator_defines.svh"
   localparam int CNT_W = $clog2(MAX_EXONS + 1);

   logic [eil_pkg::GENE_W-1:0] gene_ff;
   logic [CNT_W-1:0]           count_ff;
   logic                       rev_ff;
   logic                       busy_ff;
   logic                       rsp_valid_ff;
   eil_pkg::status_type        status_ff;
   logic                       is_exon_ff;
   logic [eil_pkg::REGION_W-1:0] region_ff;

   logic req_fire, add_fire, query_fire, full;
   logic [eil_pkg::COORD_W-1:0] raw, mag, pos;

   eil_pkg::token_type          head_tok;
   eil_pkg::token_type          tok [MAX_EXONS+1];
   logic [eil_pkg::COORD_W-1:0] firsts [MAX_EXONS];
   logic [eil_pkg::COORD_W-1:0] lasts  [MAX_EXONS];

   // one command at a time, output register must be free or leaving
   assign req_bus.ready = !busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign add_fire   = req_fire && (req_bus.cmd == eil_pkg::CMD_ADD);
   assign query_fire = req_fire && (req_bus.cmd == eil_pkg::CMD_QUERY);
   assign full       = (count_ff == CNT_W'(MAX_EXONS));
   assign csr_bus.ready = 1'b1;

   // magnitude of the signed position plus gene start, always fits 31 bits
   assign raw = req_bus.rel_position;
   assign mag = raw[eil_pkg::COORD_W-1] ? (~raw + eil_pkg::COORD_W'(1)) : raw;
   assign pos = mag + eil_pkg::COORD_W'(gene_ff);

   always_comb begin
      head_tok       = '0;
      head_tok.valid = query_fire;
      head_tok.pos   = pos;
   end

   assign tok[0] = head_tok;

   // row of cells, query word enters at cell 0
   for (genvar i = 0; i < MAX_EXONS; i++) begin : g_cell
      logic [eil_pkg::COORD_W-1:0] pf, pl;
      if (i == 0) begin : g_head
         assign pf = firsts[0];
         assign pl = lasts[0];
      end else begin : g_body
         assign pf = firsts[i-1];
         assign pl = lasts[i-1];
      end
      eil_cell #(.IS_HEAD(i == 0)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (add_fire && (count_ff == CNT_W'(i))),
         .wr_id      (req_bus.exon_id),
         .wr_first   (req_bus.exon_first),
         .wr_last    (req_bus.exon_last),
         .reversed   (rev_ff),
         .prev_first (pf),
         .prev_last  (pl),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .first_out  (firsts[i]),
         .last_out   (lasts[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gene_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) gene_ff <= csr_bus.data;
         if (rsp_valid_ff && rsp_bus.ready) rsp_valid_ff <= 1'b0;
         if (add_fire) begin
            rsp_valid_ff <= 1'b1;
            is_exon_ff   <= 1'b0;
            region_ff    <= '0;
            if (full) begin
               status_ff <= eil_pkg::ST_FULL;
            end else begin
               status_ff <= eil_pkg::ST_STORED;
               count_ff  <= count_ff + CNT_W'(1);
               // second entry decides the strand order
               if (count_ff == CNT_W'(1) && firsts[0] > req_bus.exon_first)
                  rev_ff <= 1'b1;
            end
         end
         if (query_fire) busy_ff <= 1'b1;
         // query word leaves the last cell
         if (tok[MAX_EXONS].valid) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            status_ff    <= tok[MAX_EXONS].done ? eil_pkg::ST_MATCH : eil_pkg::ST_NOMATCH;
            is_exon_ff   <= tok[MAX_EXONS].is_exon;
            region_ff    <= tok[MAX_EXONS].region;
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.is_exon       = is_exon_ff;
   assign rsp_bus.region_number = region_ff;

   `EIL_ASSERT_IMPLIES(a_busy_blocks, clock, reset, busy_ff, !req_bus.ready)
   `EIL_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_EXONS))
   `EIL_ASSERT_IMPLIES(a_tok_busy, clock, reset, tok[MAX_EXONS].valid, busy_ff)
   `EIL_ASSERT_NEXT(a_query_busy, clock, reset, query_fire, busy_ff || rsp_valid_ff)
endmodule

@@ rtl/eil_cell.sv @@
// one table cell: holds an exon and tests the passing query word
module eil_cell #(
   parameter bit IS_HEAD = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [eil_pkg::ID_W-1:0]      wr_id,
   input  logic [eil_pkg::COORD_W-1:0]   wr_first,
   input  logic [eil_pkg::COORD_W-1:0]   wr_last,
   input  logic                          reversed,
   input  logic [eil_pkg::COORD_W-1:0]   prev_first,
   input  logic [eil_pkg::COORD_W-1:0]   prev_last,
   input  eil_pkg::token_type            tok_in,
   output eil_pkg::token_type            tok_out,
   output logic [eil_pkg::COORD_W-1:0]   first_out,
   output logic [eil_pkg::COORD_W-1:0]   last_out
);
   logic                        used_ff;
   logic [eil_pkg::ID_W-1:0]    id_ff;
   logic [eil_pkg::COORD_W-1:0] first_ff, last_ff;
   eil_pkg::token_type          tok_ff, tok_ff_in;
   logic                        hit_exon, hit_gap;

   always_comb begin
      hit_exon = (tok_in.pos >= first_ff) && (tok_in.pos <= last_ff);
      if (IS_HEAD) begin
         hit_gap = 1'b0;
      end else if (reversed) begin
         hit_gap = (last_ff < tok_in.pos) && (tok_in.pos < prev_first);
      end else begin
         hit_gap = (prev_last < tok_in.pos) && (tok_in.pos < first_ff);
      end
      tok_ff_in = tok_in;
      if (tok_in.valid && !tok_in.done && used_ff) begin
         if (hit_exon) begin
            tok_ff_in.done    = 1'b1;
            tok_ff_in.is_exon = 1'b1;
            tok_ff_in.region  = {1'b0, id_ff};
         end else if (hit_gap) begin
            tok_ff_in.done    = 1'b1;
            tok_ff_in.is_exon = 1'b0;
            tok_ff_in.region  = {1'b0, id_ff} - eil_pkg::REGION_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         tok_ff <= tok_ff_in;
         if (wr_en) used_ff <= 1'b1;
      end
      if (wr_en) begin
         id_ff    <= wr_id;
         first_ff <= wr_first;
         last_ff  <= wr_last;
      end
   end

   assign tok_out   = tok_ff;
   assign first_out = first_ff;
   assign last_out  = last_ff;
endmodule
